### rtl/dsm_pkg.sv
// Shared types and constants of the four-channel DAC stereo mixer.
package dsm_pkg;

  localparam int unsigned NUM_CH   = 4;
  localparam int unsigned CFG_IDX_W = 3;

  localparam logic [7:0] LATCH_MID = 8'h80;
  localparam logic [7:0] IDLE_MAX  = 8'hFF;

  localparam logic [7:0] PORT_LA_ALT = 8'hF1;
  localparam logic [7:0] PORT_LB_ALT = 8'hF3;
  localparam logic [7:0] PORT_RA_ALT = 8'hF9;
  localparam logic [7:0] PORT_RB_ALT = 8'hFB;
  localparam logic [7:0] PORT_LA_PRI = 8'h0F;
  localparam logic [7:0] PORT_LB_PRI = 8'h1F;
  localparam logic [7:0] PORT_RA_PRI = 8'h4F;
  localparam logic [7:0] PORT_RB_PRI = 8'h5F;

  localparam logic [7:0] RST_ALT_MASK  = 8'hF5;
  localparam logic [7:0] RST_ALT_MATCH = 8'hF1;
  localparam logic [7:0] RST_PRI_MASK  = 8'hAF;
  localparam logic [7:0] RST_PRI_MATCH = 8'h0F;
  localparam logic [7:0] RST_STALE     = 8'd25;

  typedef enum logic [1:0] {
    CH_LEFT_A  = 2'd0,
    CH_LEFT_B  = 2'd1,
    CH_RIGHT_A = 2'd2,
    CH_RIGHT_B = 2'd3
  } chan_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ALT_MASK  = 3'd0,
    REG_ALT_MATCH = 3'd1,
    REG_PRI_MASK  = 3'd2,
    REG_PRI_MATCH = 3'd3,
    REG_STALE     = 3'd4,
    REG_MUTE      = 3'd5,
    REG_SUPPRESS  = 3'd6
  } cfg_idx_e;

  typedef enum logic {
    OP_WRITE = 1'b0,
    OP_FRAME = 1'b1
  } op_e;

  typedef enum logic {
    CAUSE_WRITE = 1'b0,
    CAUSE_DECAY = 1'b1
  } cause_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WRITE,
    ST_SCAN,
    ST_EMIT
  } state_e;

endpackage

### rtl/dsm_if.sv
// Channel interfaces: input items, result items and configuration writes.
interface dsm_in_if #(
  parameter int unsigned TIME_BITS = 20
);
  logic                 valid;
  logic                 ready;
  logic                 operation;
  logic [15:0]          port;
  logic [7:0]           value;
  logic [TIME_BITS-1:0] step_time;

  modport source (output valid, operation, port, value, step_time, input ready);
  modport sink   (input valid, operation, port, value, step_time, output ready);
endinterface

interface dsm_out_if #(
  parameter int unsigned TIME_BITS = 20
);
  logic                 valid;
  logic                 ready;
  logic                 cause;
  logic [1:0]           channel;
  logic [TIME_BITS-1:0] step_at;
  logic signed [16:0]   left_delta;
  logic signed [16:0]   right_delta;
  logic signed [15:0]   left_level;
  logic signed [15:0]   right_level;
  logic                 step_valid;
  logic                 frame_active;
  logic                 last;

  modport source (output valid, cause, channel, step_at, left_delta, right_delta,
                  left_level, right_level, step_valid, frame_active, last,
                  input ready);
  modport sink   (input valid, cause, channel, step_at, left_delta, right_delta,
                  left_level, right_level, step_valid, frame_active, last,
                  output ready);
endinterface

interface dsm_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [dsm_pkg::CFG_IDX_W-1:0] index;
  logic [7:0]                    data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

### rtl/four_channel_dac_stereo_mixer.sv
// Four-channel DAC latch block with stereo mixer and stale-channel decay.
// Port write: accept, latch and mix steps; the result is registered in the mix step;
//   a port that no set accepts returns to idle after the latch step without a result.
// Frame start: accept, one scan step per channel up to the last decay (all channels with no
//   decay) and one mix step per decayed channel; a held result stalls the mix step.
// Reset: latches at midpoint, counters, flags, levels cleared, registers defaulted.
module four_channel_dac_stereo_mixer #(
  parameter int unsigned TIME_BITS = 20
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  dsm_cfg_if.sink    cfg_i,
  dsm_in_if.sink     in_i,
  dsm_out_if.source  res_o
);
  import dsm_pkg::*;

  state_e state_q, state_d;
  logic [1:0] ch_q, ch_d;
  logic       last_q, cause_q;
  logic [NUM_CH-1:0] dec_q;
  logic [7:0] lo_q, val_q;
  logic [TIME_BITS-1:0] time_q;

  logic [7:0] latch_q [NUM_CH];
  logic [NUM_CH-1:0] wr_q;
  logic [7:0] idle_q [NUM_CH];
  logic signed [15:0] prev_l_q, prev_r_q;
  logic act_q;

  logic [7:0] alt_mask_q, alt_match_q, pri_mask_q, pri_match_q, stale_q;
  logic [3:0] mute_q;
  logic       sup_q;

  logic                 out_valid_q;
  logic                 out_cause_q, out_sv_q, out_fa_q, out_last_q;
  logic [1:0]           out_ch_q;
  logic [TIME_BITS-1:0] out_at_q;
  logic signed [16:0]   out_dl_q, out_dr_q;
  logic signed [15:0]   out_ll_q, out_rl_q;

  logic take_in, write_en, decay_en, emit_en, hit;
  logic [1:0] dec_ch;
  logic [NUM_CH-1:0] higher;

  logic signed [8:0] contrib [NUM_CH];
  logic signed [8:0] sole;
  logic [2:0] nz_cnt;
  logic signed [9:0] sum_l, sum_r, mix_l, mix_r;
  logic signed [15:0] lev_l, lev_r;
  logic signed [16:0] dl, dr;
  logic step_ok;

  logic [7:0] idle_inc [NUM_CH];
  logic [NUM_CH-1:0] dec_new;

  assign cfg_i.ready = 1'b1;
  assign in_i.ready  = (state_q == ST_IDLE);

  assign hit = ((lo_q & alt_mask_q) == alt_match_q) || ((lo_q & pri_mask_q) == pri_match_q);

  always_comb begin
    case (lo_q)
      PORT_LA_ALT, PORT_LA_PRI: dec_ch = CH_LEFT_A;
      PORT_LB_ALT, PORT_LB_PRI: dec_ch = CH_LEFT_B;
      PORT_RA_ALT, PORT_RA_PRI: dec_ch = CH_RIGHT_A;
      default:                  dec_ch = CH_RIGHT_B;
    endcase
  end

  assign higher = dec_q >> ch_q;

  always_comb begin
    for (int i = 0; i < NUM_CH; i++) begin
      idle_inc[i] = (idle_q[i] == IDLE_MAX) ? IDLE_MAX : idle_q[i] + 8'd1;
      dec_new[i]  = !wr_q[i] && (idle_inc[i] >= stale_q) && (latch_q[i] != LATCH_MID);
    end
  end

  // shared mix and delta unit
  always_comb begin
    sole   = '0;
    nz_cnt = '0;
    for (int i = 0; i < NUM_CH; i++) begin
      contrib[i] = mute_q[i] ? 9'sd0 : $signed({1'b0, latch_q[i]} - 9'd128);
      if (contrib[i] != 9'sd0) begin
        sole   = contrib[i];
        nz_cnt = nz_cnt + 3'd1;
      end
    end
    sum_l = 10'(contrib[0]) + 10'(contrib[1]);
    sum_r = 10'(contrib[2]) + 10'(contrib[3]);
    mix_l = (nz_cnt <= 3'd1) ? 10'(sole) : sum_l;
    mix_r = (nz_cnt <= 3'd1) ? 10'(sole) : sum_r;
    lev_l = {mix_l[8:0], 7'd0};
    lev_r = {mix_r[8:0], 7'd0};
    dl    = 17'(lev_l) - 17'(prev_l_q);
    dr    = 17'(lev_r) - 17'(prev_r_q);
    step_ok = !sup_q && ((dl != 17'sd0) || (dr != 17'sd0));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d  = state_q;
    ch_d     = ch_q;
    take_in  = 1'b0;
    write_en = 1'b0;
    decay_en = 1'b0;
    emit_en  = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (in_i.valid) begin
          take_in = 1'b1;
          ch_d    = '0;
          state_d = (in_i.operation == OP_FRAME) ? ST_SCAN : ST_WRITE;
        end
      end
      ST_WRITE: begin
        if (hit) begin
          write_en = 1'b1;
          ch_d     = dec_ch;
          state_d  = ST_EMIT;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_SCAN: begin
        if (dec_q[ch_q]) begin
          decay_en = 1'b1;
          state_d  = ST_EMIT;
        end else if (ch_q == 2'd3) begin
          state_d = ST_IDLE;
        end else begin
          ch_d = ch_q + 2'd1;
        end
      end
      ST_EMIT: begin
        if (!out_valid_q || res_o.ready) begin
          emit_en = 1'b1;
          if (last_q) begin
            state_d = ST_IDLE;
          end else begin
            ch_d    = ch_q + 2'd1;
            state_d = ST_SCAN;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ch_q        <= '0;
      last_q      <= 1'b0;
      cause_q     <= CAUSE_WRITE;
      dec_q       <= '0;
      wr_q        <= '0;
      prev_l_q    <= '0;
      prev_r_q    <= '0;
      act_q       <= 1'b0;
      out_valid_q <= 1'b0;
      alt_mask_q  <= RST_ALT_MASK;
      alt_match_q <= RST_ALT_MATCH;
      pri_mask_q  <= RST_PRI_MASK;
      pri_match_q <= RST_PRI_MATCH;
      stale_q     <= RST_STALE;
      mute_q      <= '0;
      sup_q       <= 1'b0;
      for (int i = 0; i < NUM_CH; i++) begin
        latch_q[i] <= LATCH_MID;
        idle_q[i]  <= '0;
      end
    end else begin
      ch_q <= ch_d;
      if (cfg_i.valid) begin
        case (cfg_i.index)
          REG_ALT_MASK:  alt_mask_q  <= cfg_i.data;
          REG_ALT_MATCH: alt_match_q <= cfg_i.data;
          REG_PRI_MASK:  pri_mask_q  <= cfg_i.data;
          REG_PRI_MATCH: pri_match_q <= cfg_i.data;
          REG_STALE:     stale_q     <= cfg_i.data;
          REG_MUTE:      mute_q      <= cfg_i.data[3:0];
          REG_SUPPRESS:  sup_q       <= cfg_i.data[0];
          default: ;
        endcase
      end
      if (take_in && in_i.operation == OP_FRAME) begin
        act_q <= 1'b0;
        dec_q <= dec_new;
        wr_q  <= '0;
        for (int i = 0; i < NUM_CH; i++) begin
          idle_q[i] <= wr_q[i] ? 8'd0 : idle_inc[i];
        end
      end
      if (write_en) begin
        latch_q[dec_ch] <= val_q;
        wr_q[dec_ch]    <= 1'b1;
        idle_q[dec_ch]  <= '0;
        cause_q         <= CAUSE_WRITE;
        last_q          <= 1'b1;
      end
      if (decay_en) begin
        latch_q[ch_q] <= LATCH_MID;
        cause_q       <= CAUSE_DECAY;
        last_q        <= (higher[3:1] == 3'd0);
      end
      if (emit_en) begin
        prev_l_q <= lev_l;
        prev_r_q <= lev_r;
        if (step_ok) begin
          act_q <= 1'b1;
        end
        out_valid_q <= 1'b1;
      end else if (res_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_in) begin
      lo_q   <= in_i.port[7:0];
      val_q  <= in_i.value;
      time_q <= in_i.step_time;
    end
    if (emit_en) begin
      out_cause_q <= cause_q;
      out_ch_q    <= ch_q;
      out_at_q    <= (cause_q == CAUSE_DECAY) ? '0 : time_q;
      out_dl_q    <= dl;
      out_dr_q    <= dr;
      out_ll_q    <= lev_l;
      out_rl_q    <= lev_r;
      out_sv_q    <= step_ok;
      out_fa_q    <= act_q | step_ok;
      out_last_q  <= last_q;
    end
  end

  assign res_o.valid        = out_valid_q;
  assign res_o.cause        = out_cause_q;
  assign res_o.channel      = out_ch_q;
  assign res_o.step_at      = out_at_q;
  assign res_o.left_delta   = out_dl_q;
  assign res_o.right_delta  = out_dr_q;
  assign res_o.left_level   = out_ll_q;
  assign res_o.right_level  = out_rl_q;
  assign res_o.step_valid   = out_sv_q;
  assign res_o.frame_active = out_fa_q;
  assign res_o.last         = out_last_q;

endmodule

### tb/testbench.sv
`timescale 1ns / 100ps
// Self-checking testbench for the four-channel DAC stereo mixer with its scoreboard.
module testbench;
  import dsm_pkg::*;

  localparam int unsigned TIME_BITS        = 20;
  localparam int unsigned LONG_HOLD_CYCLES = 200;
  localparam int unsigned SETTLE_CYCLES    = 16;
  localparam int unsigned TIMEOUT_NS       = 400000;
  localparam int          MIX_GAIN         = 128;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

  typedef struct {
    cause_e                 cause;
    logic [1:0]             channel;
    logic [TIME_BITS-1:0]   step_at;
    logic signed [16:0]     left_delta;
    logic signed [16:0]     right_delta;
    logic signed [15:0]     left_level;
    logic signed [15:0]     right_level;
    logic                   step_valid;
    logic                   frame_active;
    logic                   last;
  } mix_result_t;

  class mixer_scoreboard;
    logic [7:0]  alt_mask, alt_match, pri_mask, pri_match, stale_limit;
    logic [3:0]  mute;
    logic        suppress;
    logic [7:0]  latch [NUM_CH];
    bit          written [NUM_CH];
    logic [7:0]  idle_cnt [NUM_CH];
    int          prev_left, prev_right;
    bit          activity;
    mix_result_t mix_results_q [$];
    int unsigned mismatches, results_seen, decay_steps, items_seen;

    function new();
      alt_mask    = RST_ALT_MASK;
      alt_match   = RST_ALT_MATCH;
      pri_mask    = RST_PRI_MASK;
      pri_match   = RST_PRI_MATCH;
      stale_limit = RST_STALE;
      mute        = 4'h0;
      suppress    = 1'b0;
      for (int i = 0; i < NUM_CH; i++) begin
        latch[i]    = LATCH_MID;
        written[i]  = 1'b0;
        idle_cnt[i] = 8'd0;
      end
      prev_left    = 0;
      prev_right   = 0;
      activity     = 1'b0;
      mismatches   = 0;
      results_seen = 0;
      decay_steps  = 0;
      items_seen   = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [7:0] data);
      case (idx)
        REG_ALT_MASK:  alt_mask    = data;
        REG_ALT_MATCH: alt_match   = data;
        REG_PRI_MASK:  pri_mask    = data;
        REG_PRI_MATCH: pri_match   = data;
        REG_STALE:     stale_limit = data;
        REG_MUTE:      mute        = data[3:0];
        REG_SUPPRESS:  suppress    = data[0];
        default: ;
      endcase
    endfunction

    function mix_result_t mix_step(cause_e cause, logic [1:0] ch, logic [TIME_BITS-1:0] at);
      int          c [NUM_CH];
      int          sole, active, new_left, new_right, dl, dr;
      mix_result_t r;
      sole   = 0;
      active = 0;
      for (int i = 0; i < NUM_CH; i++) begin
        c[i] = mute[i] ? 0 : int'(latch[i]) - int'(LATCH_MID);
        if (c[i] != 0) begin
          sole = c[i];
          active++;
        end
      end
      if (active <= 1) begin
        new_left  = sole * MIX_GAIN;
        new_right = sole * MIX_GAIN;
      end else begin
        new_left  = (c[0] + c[1]) * MIX_GAIN;
        new_right = (c[2] + c[3]) * MIX_GAIN;
      end
      dl = new_left - prev_left;
      dr = new_right - prev_right;
      r.step_valid = !suppress && (dl != 0 || dr != 0);
      if (r.step_valid) activity = 1'b1;
      prev_left      = new_left;
      prev_right     = new_right;
      r.cause        = cause;
      r.channel      = ch;
      r.step_at      = at;
      r.left_delta   = dl[16:0];
      r.right_delta  = dr[16:0];
      r.left_level   = new_left[15:0];
      r.right_level  = new_right[15:0];
      r.frame_active = activity;
      r.last         = 1'b0;
      return r;
    endfunction

    function void note_item(op_e op, logic [15:0] port, logic [7:0] val,
                            logic [TIME_BITS-1:0] at);
      logic [7:0]  lo;
      logic [1:0]  ch;
      mix_result_t held;
      bit          have_held;
      items_seen++;
      have_held = 1'b0;
      if (op == OP_WRITE) begin
        lo = port[7:0];
        if ((lo & alt_mask) != alt_match && (lo & pri_mask) != pri_match) return;
        case (lo)
          PORT_LA_ALT, PORT_LA_PRI: ch = CH_LEFT_A;
          PORT_LB_ALT, PORT_LB_PRI: ch = CH_LEFT_B;
          PORT_RA_ALT, PORT_RA_PRI: ch = CH_RIGHT_A;
          default:                  ch = CH_RIGHT_B;
        endcase
        latch[ch]    = val;
        written[ch]  = 1'b1;
        idle_cnt[ch] = 8'd0;
        held = mix_step(CAUSE_WRITE, ch, at);
        held.last = 1'b1;
        mix_results_q.push_back(held);
      end else begin
        activity = 1'b0;
        for (int i = 0; i < NUM_CH; i++) begin
          if (written[i]) begin
            idle_cnt[i] = 8'd0;
          end else begin
            if (idle_cnt[i] != IDLE_MAX) idle_cnt[i]++;
            if (idle_cnt[i] >= stale_limit && latch[i] != LATCH_MID) begin
              latch[i] = LATCH_MID;
              if (have_held) mix_results_q.push_back(held);
              held = mix_step(CAUSE_DECAY, 2'(i), '0);
              have_held = 1'b1;
              decay_steps++;
            end
          end
          written[i] = 1'b0;
        end
        if (have_held) begin
          held.last = 1'b1;
          mix_results_q.push_back(held);
        end
      end
    endfunction

    task report_mismatch(string field, int got, int want);
      mismatches++;
      $display("%0t: result %0d, %s mismatch: got %0d, expected %0d",
               $time, results_seen, field, got, want);
    endtask

    task check_result(mix_result_t got);
      mix_result_t want;
      results_seen++;
      if (mix_results_q.size() == 0) begin
        report_mismatch("unexpected result", 1, 0);
        return;
      end
      want = mix_results_q.pop_front();
      if (got.cause !== want.cause) report_mismatch("cause", got.cause, want.cause);
      if (got.channel !== want.channel) report_mismatch("channel", got.channel, want.channel);
      if (got.step_at !== want.step_at) report_mismatch("step_at", got.step_at, want.step_at);
      if (got.left_delta !== want.left_delta)
        report_mismatch("left_delta", got.left_delta, want.left_delta);
      if (got.right_delta !== want.right_delta)
        report_mismatch("right_delta", got.right_delta, want.right_delta);
      if (got.left_level !== want.left_level)
        report_mismatch("left_level", got.left_level, want.left_level);
      if (got.right_level !== want.right_level)
        report_mismatch("right_level", got.right_level, want.right_level);
      if (got.step_valid !== want.step_valid)
        report_mismatch("step_valid", got.step_valid, want.step_valid);
      if (got.frame_active !== want.frame_active)
        report_mismatch("frame_active", got.frame_active, want.frame_active);
      if (got.last !== want.last) report_mismatch("last", got.last, want.last);
    endtask
  endclass

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  int unsigned idle_pct = 6;
  int unsigned settings_used = 0;
  bit          long_hold = 1'b0;

  mixer_scoreboard sb = new();

  dsm_cfg_if                           cfg_if ();
  dsm_in_if  #(.TIME_BITS(TIME_BITS))  in_if ();
  dsm_out_if #(.TIME_BITS(TIME_BITS))  res_if ();

  four_channel_dac_stereo_mixer #(.TIME_BITS(TIME_BITS)) dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_if),
    .in_i   (in_if),
    .res_o  (res_if)
  );

  always #1 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    mix_result_t got;
    if (rst_ni) begin
      if (res_if.valid && res_if.ready) begin
        got.cause        = cause_e'(res_if.cause);
        got.channel      = res_if.channel;
        got.step_at      = res_if.step_at;
        got.left_delta   = res_if.left_delta;
        got.right_delta  = res_if.right_delta;
        got.left_level   = res_if.left_level;
        got.right_level  = res_if.right_level;
        got.step_valid   = res_if.step_valid;
        got.frame_active = res_if.frame_active;
        got.last         = res_if.last;
        sb.check_result(got);
      end
      if (in_if.valid && in_if.ready)
        sb.note_item(op_e'(in_if.operation), in_if.port, in_if.value, in_if.step_time);
    end
  end

  initial begin
    res_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (long_hold) begin
        res_if.ready <= 1'b0;
        for (int n = 0; n < LONG_HOLD_CYCLES; n++) @(posedge clk_i);
        long_hold = 1'b0;
      end
      res_if.ready <= ($urandom_range(99) >= idle_pct);
    end
  end

  function automatic logic [7:0] decoded_byte(int unsigned k);
    case (k)
      0:       return PORT_LA_ALT;
      1:       return PORT_LB_ALT;
      2:       return PORT_RA_ALT;
      3:       return PORT_RB_ALT;
      4:       return PORT_LA_PRI;
      5:       return PORT_LB_PRI;
      6:       return PORT_RA_PRI;
      default: return PORT_RB_PRI;
    endcase
  endfunction

  task automatic send_item(op_e op, logic [15:0] port, logic [7:0] val,
                           logic [TIME_BITS-1:0] at);
    while ($urandom_range(99) < idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid     <= 1'b1;
    in_if.operation <= op;
    in_if.port      <= port;
    in_if.value     <= val;
    in_if.step_time <= at;
    do @(posedge clk_i); while (!in_if.ready);
  endtask

  task automatic stop_sending();
    in_if.valid <= 1'b0;
  endtask

  task automatic drain();
    @(posedge clk_i);
    while (sb.mix_results_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [7:0] data);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= data;
    do @(posedge clk_i); while (!cfg_if.ready);
    sb.set_reg(idx, data);
  endtask

  task automatic configure(logic [7:0] alt_mask, logic [7:0] alt_match,
                           logic [7:0] pri_mask, logic [7:0] pri_match,
                           logic [7:0] stale, logic [3:0] mute, logic suppress);
    write_reg(REG_UNUSED, 8'($urandom));
    write_reg(REG_ALT_MASK, alt_mask);
    write_reg(REG_ALT_MATCH, alt_match);
    write_reg(REG_PRI_MASK, pri_mask);
    write_reg(REG_PRI_MATCH, pri_match);
    write_reg(REG_STALE, stale);
    write_reg(REG_MUTE, {4'($urandom), mute});
    write_reg(REG_SUPPRESS, {7'($urandom), suppress});
    cfg_if.valid <= 1'b0;
    settings_used++;
  endtask

  task automatic run_random(int unsigned count, int unsigned frame_pct);
    logic [15:0]          port;
    logic [7:0]           val;
    logic [TIME_BITS-1:0] at;
    repeat (count) begin
      port = 16'($urandom);
      at   = TIME_BITS'($urandom);
      if ($urandom_range(99) < 75) port[7:0] = decoded_byte($urandom_range(7));
      case ($urandom_range(9))
        0, 1:    val = LATCH_MID;
        2:       val = 8'h00;
        3:       val = 8'hFF;
        default: val = 8'($urandom);
      endcase
      if ($urandom_range(99) < frame_pct) send_item(OP_FRAME, port, val, at);
      else send_item(OP_WRITE, port, val, at);
    end
    stop_sending();
    drain();
  endtask

  initial begin
    in_if.valid     <= 1'b0;
    in_if.operation <= OP_WRITE;
    in_if.port      <= '0;
    in_if.value     <= '0;
    in_if.step_time <= '0;
    cfg_if.valid    <= 1'b0;
    cfg_if.index    <= '0;
    cfg_if.data     <= '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_item(OP_WRITE, {8'h00, PORT_LA_ALT}, 8'hFF, '0);
    send_item(OP_WRITE, {8'hFF, PORT_LB_PRI}, 8'h00, '1);
    send_item(OP_WRITE, {8'hA5, PORT_RA_ALT}, 8'h00, TIME_BITS'($urandom));
    send_item(OP_WRITE, {8'h5A, PORT_RB_PRI}, 8'hFF, TIME_BITS'($urandom));
    send_item(OP_WRITE, {8'h5A, PORT_RB_PRI}, 8'hFF, TIME_BITS'($urandom));
    send_item(OP_WRITE, 16'hFFFE, 8'h12, TIME_BITS'($urandom));
    send_item(OP_WRITE, 16'h0000, 8'h34, TIME_BITS'($urandom));
    send_item(OP_WRITE, {8'h01, PORT_LA_PRI}, LATCH_MID, TIME_BITS'($urandom));
    send_item(OP_WRITE, {8'h80, PORT_LB_ALT}, LATCH_MID, TIME_BITS'($urandom));
    send_item(OP_WRITE, {8'h7F, PORT_RA_PRI}, LATCH_MID, TIME_BITS'($urandom));
    send_item(OP_WRITE, {8'hC3, PORT_RB_ALT}, 8'h7F, TIME_BITS'($urandom));
    send_item(OP_FRAME, 16'($urandom), 8'($urandom), TIME_BITS'($urandom));
    stop_sending();
    drain();

    configure(RST_ALT_MASK, RST_ALT_MATCH, RST_PRI_MASK, RST_PRI_MATCH, 8'd1, 4'h0, 1'b0);
    send_item(OP_WRITE, {8'h00, PORT_LA_ALT}, 8'h01, TIME_BITS'($urandom));
    send_item(OP_WRITE, {8'hFF, PORT_LB_PRI}, 8'hFE, TIME_BITS'($urandom));
    send_item(OP_WRITE, {8'h3C, PORT_RA_ALT}, 8'h81, TIME_BITS'($urandom));
    send_item(OP_WRITE, {8'hC3, PORT_RB_PRI}, 8'h00, TIME_BITS'($urandom));
    send_item(OP_FRAME, 16'($urandom), 8'($urandom), TIME_BITS'($urandom));
    send_item(OP_FRAME, 16'($urandom), 8'($urandom), TIME_BITS'($urandom));
    send_item(OP_WRITE, {8'h66, PORT_RA_PRI}, 8'h10, TIME_BITS'($urandom));
    repeat (3) send_item(OP_FRAME, 16'($urandom), 8'($urandom), TIME_BITS'($urandom));
    stop_sending();
    drain();

    configure(RST_ALT_MASK, RST_ALT_MATCH, RST_PRI_MASK, RST_PRI_MATCH, 8'd2, 4'h0, 1'b0);
    long_hold = 1'b1;
    run_random(40, 20);

    configure(8'h00, 8'h00, 8'h00, 8'h00, 8'd1, 4'hA, 1'b0);
    run_random(30, 25);

    configure(8'hFF, 8'hFF, 8'hF0, 8'h00, 8'd3, 4'hF, 1'b1);
    run_random(20, 25);

    idle_pct = 0;
    configure(RST_ALT_MASK, RST_ALT_MATCH, RST_PRI_MASK, RST_PRI_MATCH, 8'd0, 4'h5, 1'b0);
    run_random(25, 20);
    idle_pct = 6;

    configure(RST_ALT_MASK, RST_ALT_MATCH, RST_PRI_MASK, RST_PRI_MATCH, 8'd60, 4'h0, 1'b0);
    send_item(OP_WRITE, {8'h11, PORT_LA_ALT}, 8'h33, TIME_BITS'($urandom));
    repeat (62) send_item(OP_FRAME, 16'($urandom), 8'($urandom), TIME_BITS'($urandom));
    send_item(OP_WRITE, {8'hEE, PORT_RB_PRI}, 8'h90, TIME_BITS'($urandom));
    repeat (2) send_item(OP_FRAME, 16'($urandom), 8'($urandom), TIME_BITS'($urandom));
    stop_sending();
    drain();

    configure(8'hF0, 8'hF0, RST_PRI_MASK, RST_PRI_MATCH, 8'd1, 4'h2, 1'b1);
    run_random(20, 25);

    configure(RST_ALT_MASK, RST_ALT_MATCH, RST_PRI_MASK, RST_PRI_MATCH, 8'd1, 4'h0, 1'b0);
    run_random(25, 30);

    $display("Summary: %0d input transactions, %0d results checked, %0d of them decay steps.",
             sb.items_seen, sb.results_seen, sb.decay_steps);
    $display("Summary: %0d register settings, one %0d-cycle output stall, %0d mismatches.",
             settings_used, LONG_HOLD_CYCLES, sb.mismatches);
    if (sb.mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #TIMEOUT_NS;
    $display("Timeout with %0d results outstanding", sb.mix_results_q.size());
    $display("Simulation FAILED");
    $finish;
  end

endmodule

### sim.f
rtl/dsm_pkg.sv
rtl/dsm_if.sv
rtl/four_channel_dac_stereo_mixer.sv
tb/testbench.sv
